[rtl/core/clfr_pkg.sv]
// Shared types and constants for the character LCD frame refresher.
// Item and result structs, controller/datapath command and status, bus codes.
// No dependencies.
package clfr_pkg;

    // Field and register widths fixed by the interface
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 6;

    // Input item modes
    localparam logic [1:0] MODE_START    = 2'd0;
    localparam logic [1:0] MODE_DATA     = 2'd1;
    localparam logic [1:0] MODE_BUS_DONE = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_BUS     = 2'd0;
    localparam logic [1:0] KIND_NOTICE  = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_WIDTH    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_COUNT    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LEFT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TOP    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_RIGHT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_BOTTOM = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_NOTIFY_ENABLE = 3'd6;

    // Register reset values
    localparam logic [5:0] RST_LINE_WIDTH    = 6'd16;
    localparam logic [2:0] RST_LINE_COUNT    = 3'd2;
    localparam logic [5:0] RST_WINDOW_LEFT   = 6'd0;
    localparam logic [1:0] RST_WINDOW_TOP    = 2'd0;
    localparam logic [5:0] RST_WINDOW_RIGHT  = 6'd15;
    localparam logic [1:0] RST_WINDOW_BOTTOM = 2'd1;

    // LCD bus codes
    localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
    localparam logic [7:0] CMD_CURSOR_SHIFT = 8'h10;
    localparam logic [7:0] CMD_SET_ADDR     = 8'h80;
    localparam logic [7:0] ADDR_LINE_OFFSET = 8'h40;
    localparam logic [7:0] CHAR_SPACE       = 8'h20;
    localparam logic [7:0] TOTAL_MAX        = 8'hFF;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic       end_of_write;
    } item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       rs_level;
        logic [7:0] bus_byte;
        logic       burst_last;
        logic [7:0] accepted_count;
    } result_t;

    // Refresh phase of the display
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_RESET,
        PH_ADDR,
        PH_DATA
    } phase_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SETUP,
        ST_POS_EOW,
        ST_SUMMARY,
        ST_POS,
        ST_NOTICE,
        ST_CHAR
    } ctrl_state_t;

    // Source of an emitted result
    typedef enum logic [2:0] {
        SRC_SETUP,
        SRC_POS,
        SRC_CHAR,
        SRC_NOTICE,
        SRC_SUMMARY
    } emit_src_t;

    typedef struct packed {
        logic      capture;
        logic      store;
        logic      phase_we;
        phase_t    phase_val;
        logic      line_clr;
        logic      line_inc;
        logic      pend_set;
        logic      pend_clr;
        logic      wpos_clr;
        logic      seq_clr;
        logic      seq_inc;
        logic      rd_start;
        logic      rd_next;
        logic      emit;
        emit_src_t src;
        logic      last;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       end_of_write;
        phase_t     phase;
        logic       pending;
        logic       notify;
        logic       more_lines;
        logic       can_emit;
        logic       seq_last;
        logic       char_last;
    } status_t;

    // Set-up command sequence
    function automatic logic [7:0] setup_cmd(input logic [1:0] step);
        logic [7:0] code;
        unique case (step)
            2'd0: code = CMD_FUNCTION_SET;
            2'd1: code = CMD_DISPLAY_ON;
            2'd2: code = CMD_ENTRY_MODE;
            2'd3: code = CMD_CURSOR_SHIFT;
            default: code = CMD_CURSOR_SHIFT;
        endcase
        return code;
    endfunction

endpackage

[rtl/core/clfr_ctrl.sv]
// Sequencing controller of the character LCD frame refresher.
// Decodes each item and steps the datapath one result at a time.
// Depends on clfr_pkg.
module clfr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  clfr_pkg::status_t st,
    output clfr_pkg::cmd_t    cmd
);

    clfr_pkg::ctrl_state_t state_reg;
    clfr_pkg::ctrl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= clfr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            clfr_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = clfr_pkg::ST_EXEC;
                end
            end
            clfr_pkg::ST_EXEC:
            begin
                priority if (st.mode == clfr_pkg::MODE_START)
                begin
                    state_next = clfr_pkg::ST_SETUP;
                end
                else if (st.mode == clfr_pkg::MODE_DATA)
                begin
                    priority if (!st.end_of_write)
                        state_next = clfr_pkg::ST_IDLE;
                    else if (st.phase == clfr_pkg::PH_IDLE)
                        state_next = clfr_pkg::ST_POS_EOW;
                    else
                        state_next = clfr_pkg::ST_SUMMARY;
                end
                else if (st.mode == clfr_pkg::MODE_BUS_DONE)
                begin
                    priority if (st.phase == clfr_pkg::PH_ADDR)
                        state_next = clfr_pkg::ST_CHAR;
                    else if (st.phase == clfr_pkg::PH_DATA && st.more_lines)
                        state_next = clfr_pkg::ST_POS;
                    else if (st.pending)
                        state_next = clfr_pkg::ST_POS;
                    else if (st.notify)
                        state_next = clfr_pkg::ST_NOTICE;
                    else
                        state_next = clfr_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = clfr_pkg::ST_IDLE;
                end
            end
            clfr_pkg::ST_SETUP:
            begin
                if (st.can_emit && st.seq_last)
                    state_next = clfr_pkg::ST_IDLE;
            end
            clfr_pkg::ST_POS_EOW:
            begin
                if (st.can_emit)
                    state_next = clfr_pkg::ST_SUMMARY;
            end
            clfr_pkg::ST_SUMMARY, clfr_pkg::ST_POS, clfr_pkg::ST_NOTICE:
            begin
                if (st.can_emit)
                    state_next = clfr_pkg::ST_IDLE;
            end
            clfr_pkg::ST_CHAR:
            begin
                if (st.can_emit && st.char_last)
                    state_next = clfr_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = clfr_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath
    always_comb
    begin
        cmd           = '0;
        cmd.phase_val = clfr_pkg::PH_IDLE;
        cmd.src       = clfr_pkg::SRC_SETUP;
        item_stall    = 1'b1;
        unique case (state_reg)
            clfr_pkg::ST_IDLE:
            begin
                item_stall  = 1'b0;
                cmd.capture = item_valid;
            end
            clfr_pkg::ST_EXEC:
            begin
                priority if (st.mode == clfr_pkg::MODE_START)
                begin
                    cmd.phase_we  = 1'b1;
                    cmd.phase_val = clfr_pkg::PH_RESET;
                    cmd.line_clr  = 1'b1;
                    cmd.pend_set  = 1'b1;
                    cmd.seq_clr   = 1'b1;
                end
                else if (st.mode == clfr_pkg::MODE_DATA)
                begin
                    cmd.store = 1'b1;
                    if (st.end_of_write)
                    begin
                        if (st.phase == clfr_pkg::PH_IDLE)
                        begin
                            cmd.phase_we  = 1'b1;
                            cmd.phase_val = clfr_pkg::PH_ADDR;
                            cmd.line_clr  = 1'b1;
                        end
                        else
                        begin
                            cmd.pend_set = 1'b1;
                        end
                    end
                end
                else if (st.mode == clfr_pkg::MODE_BUS_DONE)
                begin
                    cmd.phase_we = 1'b1;
                    priority if (st.phase == clfr_pkg::PH_ADDR)
                    begin
                        cmd.phase_val = clfr_pkg::PH_DATA;
                        cmd.rd_start  = 1'b1;
                    end
                    else if (st.phase == clfr_pkg::PH_DATA && st.more_lines)
                    begin
                        cmd.phase_val = clfr_pkg::PH_ADDR;
                        cmd.line_inc  = 1'b1;
                    end
                    else if (st.pending)
                    begin
                        // refresh restarts from the top line
                        cmd.phase_val = clfr_pkg::PH_ADDR;
                        cmd.line_clr  = 1'b1;
                        cmd.pend_clr  = 1'b1;
                    end
                    else
                    begin
                        cmd.phase_val = clfr_pkg::PH_IDLE;
                    end
                end
                else
                begin
                    cmd.store = 1'b0;
                end
            end
            clfr_pkg::ST_SETUP:
            begin
                cmd.emit    = st.can_emit;
                cmd.src     = clfr_pkg::SRC_SETUP;
                cmd.last    = st.seq_last;
                cmd.seq_inc = st.can_emit;
            end
            clfr_pkg::ST_POS_EOW:
            begin
                cmd.emit = st.can_emit;
                cmd.src  = clfr_pkg::SRC_POS;
            end
            clfr_pkg::ST_SUMMARY:
            begin
                cmd.emit     = st.can_emit;
                cmd.src      = clfr_pkg::SRC_SUMMARY;
                cmd.last     = 1'b1;
                cmd.wpos_clr = st.can_emit;
            end
            clfr_pkg::ST_POS:
            begin
                cmd.emit = st.can_emit;
                cmd.src  = clfr_pkg::SRC_POS;
                cmd.last = 1'b1;
            end
            clfr_pkg::ST_NOTICE:
            begin
                cmd.emit = st.can_emit;
                cmd.src  = clfr_pkg::SRC_NOTICE;
                cmd.last = 1'b1;
            end
            clfr_pkg::ST_CHAR:
            begin
                cmd.emit    = st.can_emit;
                cmd.src     = clfr_pkg::SRC_CHAR;
                cmd.last    = st.char_last;
                cmd.rd_next = st.can_emit && !st.char_last;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // An accepted item is always decoded in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (state_reg == clfr_pkg::ST_EXEC))
        else $error("accepted item not decoded");

    // No result is pushed into an occupied, stalled output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> st.can_emit)
        else $error("result emitted while output register blocked");

    // The last result of an item hands control back for the next item
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.last) |=> (state_reg == clfr_pkg::ST_IDLE))
        else $error("controller not idle after last result");

endmodule

[rtl/core/clfr_datapath.sv]
// Datapath of the character LCD frame refresher: registers, frame buffer,
// write window arithmetic, refresh read-out and the result register.
// Depends on clfr_pkg.
module clfr_datapath #(
    parameter int MAX_WIDTH = 40,
    parameter int MAX_LINES = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [clfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [clfr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  clfr_pkg::item_t                     item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output clfr_pkg::result_t                   result,
    input  clfr_pkg::cmd_t                      cmd,
    output clfr_pkg::status_t                   st
);

    localparam int DEPTH  = MAX_WIDTH * MAX_LINES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [5:0] MAX_W6   = 6'(MAX_WIDTH);
    localparam logic [2:0] MAX_L3   = 3'(MAX_LINES);
    localparam logic [8:0] DEPTH9   = 9'(DEPTH);

    // Configuration registers
    logic [5:0] line_width_reg;
    logic [2:0] line_count_reg;
    logic [5:0] win_left_reg;
    logic [1:0] win_top_reg;
    logic [5:0] win_right_reg;
    logic [1:0] win_bottom_reg;
    logic       notify_reg;

    // Captured item
    clfr_pkg::item_t item_reg;

    // Refresh and write state
    clfr_pkg::phase_t phase_reg, phase_next;
    logic [1:0] line_reg, line_next;
    logic       pend_reg, pend_next;
    logic [1:0] wrow_reg, wrow_next;
    logic [5:0] wcol_reg, wcol_next;
    logic [7:0] total_reg, total_next;
    logic [1:0] seq_reg, seq_next;

    // Read-out
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic [5:0]        ccnt_reg;
    logic [7:0]        rd_data_reg;
    logic              rd_valid_reg;

    // Frame buffer; entries never written read as spaces
    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;

    // Result register
    clfr_pkg::result_t res_reg, res_next;
    logic              res_valid_reg;

    // Geometry and window arithmetic
    logic [5:0]        eff_w;
    logic [2:0]        eff_l;
    logic              win_ok;
    logic [6:0]        span;
    logic              in_win;
    logic [8:0]        idx_sum;
    logic              store_ok;
    logic [ADDR_W-1:0] wr_addr;
    logic [6:0]        col_inc;
    logic              wrap;
    logic [8:0]        rd_base;
    logic              can_emit;

    // Clamped geometry
    always_comb
    begin
        priority if (line_width_reg == 6'd0)
            eff_w = 6'd1;
        else if (line_width_reg > MAX_W6)
            eff_w = MAX_W6;
        else
            eff_w = line_width_reg;
        priority if (line_count_reg == 3'd0)
            eff_l = 3'd1;
        else if (line_count_reg > MAX_L3)
            eff_l = MAX_L3;
        else
            eff_l = line_count_reg;
    end

    // Write window position and buffer address
    always_comb
    begin
        win_ok   = (win_left_reg <= win_right_reg) && (win_top_reg <= win_bottom_reg)
                   && (win_right_reg < eff_w) && ({1'b0, win_bottom_reg} < eff_l);
        span     = {1'b0, win_right_reg} - {1'b0, win_left_reg} + 7'd1;
        in_win   = (wrow_reg <= win_bottom_reg) && ({1'b0, wcol_reg} < span);
        idx_sum  = ({7'd0, wrow_reg} * {3'd0, eff_w}) + {3'd0, win_left_reg}
                   + {3'd0, wcol_reg};
        store_ok = cmd.store && win_ok && in_win && (idx_sum < DEPTH9);
        wr_addr  = idx_sum[ADDR_W-1:0];
        col_inc  = {1'b0, wcol_reg} + 7'd1;
        wrap     = (col_inc >= span) && (wrow_reg < win_bottom_reg);
        rd_base  = {7'd0, line_reg} * {3'd0, eff_w};
        rd_addr  = cmd.rd_start ? rd_base[ADDR_W-1:0] : rd_addr_reg + ADDR_W'(1);
        can_emit = !res_valid_reg || !result_stall;
    end

    // Next values of the refresh and write state
    always_comb
    begin
        phase_next = cmd.phase_we ? cmd.phase_val : phase_reg;

        line_next = line_reg;
        if (cmd.line_clr)
            line_next = 2'd0;
        else if (cmd.line_inc)
            line_next = line_reg + 2'd1;

        pend_next = pend_reg;
        if (cmd.pend_set)
            pend_next = 1'b1;
        else if (cmd.pend_clr)
            pend_next = 1'b0;

        wrow_next  = wrow_reg;
        wcol_next  = wcol_reg;
        total_next = total_reg;
        priority if (cmd.wpos_clr)
        begin
            wrow_next  = win_top_reg;
            wcol_next  = 6'd0;
            total_next = 8'd0;
        end
        else if (store_ok)
        begin
            if (total_reg != clfr_pkg::TOTAL_MAX)
                total_next = total_reg + 8'd1;
            wcol_next = wrap ? 6'd0 : col_inc[5:0];
            wrow_next = wrap ? wrow_reg + 2'd1 : wrow_reg;
        end
        else
        begin
            wcol_next = wcol_reg;
        end

        seq_next = seq_reg;
        if (cmd.seq_clr)
            seq_next = 2'd0;
        else if (cmd.seq_inc)
            seq_next = seq_reg + 2'd1;
    end

    // Configuration and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= clfr_pkg::RST_LINE_WIDTH;
            line_count_reg <= clfr_pkg::RST_LINE_COUNT;
            win_left_reg   <= clfr_pkg::RST_WINDOW_LEFT;
            win_top_reg    <= clfr_pkg::RST_WINDOW_TOP;
            win_right_reg  <= clfr_pkg::RST_WINDOW_RIGHT;
            win_bottom_reg <= clfr_pkg::RST_WINDOW_BOTTOM;
            notify_reg     <= 1'b0;
            phase_reg      <= clfr_pkg::PH_RESET;
            line_reg       <= 2'd0;
            pend_reg       <= 1'b1;
            wrow_reg       <= clfr_pkg::RST_WINDOW_TOP;
            wcol_reg       <= 6'd0;
            total_reg      <= 8'd0;
            seq_reg        <= 2'd0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    clfr_pkg::REG_LINE_WIDTH:    line_width_reg <= cfg_data;
                    clfr_pkg::REG_LINE_COUNT:    line_count_reg <= cfg_data[2:0];
                    clfr_pkg::REG_WINDOW_LEFT:   win_left_reg   <= cfg_data;
                    clfr_pkg::REG_WINDOW_TOP:    win_top_reg    <= cfg_data[1:0];
                    clfr_pkg::REG_WINDOW_RIGHT:  win_right_reg  <= cfg_data;
                    clfr_pkg::REG_WINDOW_BOTTOM: win_bottom_reg <= cfg_data[1:0];
                    clfr_pkg::REG_NOTIFY_ENABLE: notify_reg     <= cfg_data[0];
                    default:                     notify_reg     <= notify_reg;
                endcase
            end
            phase_reg <= phase_next;
            line_reg  <= line_next;
            pend_reg  <= pend_next;
            wrow_reg  <= wrow_next;
            wcol_reg  <= wcol_next;
            total_reg <= total_next;
            seq_reg   <= seq_next;
            if (cmd.emit)
                res_valid_reg <= 1'b1;
            else if (!result_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // Item capture and read-out counters
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= item;
        if (cmd.rd_start)
            ccnt_reg <= 6'd0;
        else if (cmd.rd_next)
            ccnt_reg <= ccnt_reg + 6'd1;
        if (cmd.rd_start || cmd.rd_next)
            rd_addr_reg <= rd_addr;
    end

    // Frame buffer write and registered read
    always_ff @(posedge clk)
    begin
        if (store_ok)
            mem[wr_addr] <= item_reg.data_byte;
        if (cmd.rd_start || cmd.rd_next)
            rd_data_reg <= mem[rd_addr];
    end

    // Written flags, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (store_ok)
                valid_reg[wr_addr] <= 1'b1;
            if (cmd.rd_start || cmd.rd_next)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Result selection
    always_comb
    begin
        res_next            = '0;
        res_next.burst_last = cmd.last;
        unique case (cmd.src)
            clfr_pkg::SRC_SETUP:
            begin
                res_next.kind     = clfr_pkg::KIND_BUS;
                res_next.bus_byte = clfr_pkg::setup_cmd(seq_reg);
            end
            clfr_pkg::SRC_POS:
            begin
                res_next.kind     = clfr_pkg::KIND_BUS;
                res_next.bus_byte = clfr_pkg::CMD_SET_ADDR
                                    | ((line_reg != 2'd0) ? clfr_pkg::ADDR_LINE_OFFSET : 8'd0);
            end
            clfr_pkg::SRC_CHAR:
            begin
                res_next.kind     = clfr_pkg::KIND_BUS;
                res_next.rs_level = 1'b1;
                res_next.bus_byte = rd_valid_reg ? rd_data_reg : clfr_pkg::CHAR_SPACE;
            end
            clfr_pkg::SRC_NOTICE:
            begin
                res_next.kind = clfr_pkg::KIND_NOTICE;
            end
            clfr_pkg::SRC_SUMMARY:
            begin
                res_next.kind           = clfr_pkg::KIND_SUMMARY;
                res_next.accepted_count = total_reg;
            end
            default:
            begin
                res_next.kind = clfr_pkg::KIND_BUS;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
            res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // Status to the controller
    always_comb
    begin
        st              = '0;
        st.mode         = item_reg.mode;
        st.end_of_write = item_reg.end_of_write;
        st.phase        = phase_reg;
        st.pending      = pend_reg;
        st.notify       = notify_reg;
        st.more_lines   = ({1'b0, line_reg} + 3'd1) < eff_l;
        st.can_emit     = can_emit;
        st.seq_last     = (seq_reg == 2'd3);
        st.char_last    = (ccnt_reg == (eff_w - 6'd1));
    end

    // The single buffer port is never asked to write and read at once
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> !(cmd.rd_start || cmd.rd_next))
        else $error("buffer write collides with read-out");

    // Refresh line never leaves the configured maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.line_inc |=> ({1'b0, line_reg} < MAX_L3))
        else $error("refresh line beyond display");

endmodule

[rtl/core/char_lcd_frame_refresher.sv]
// Character LCD frame refresher: frame buffer and LCD bus byte sequencer.
// An item is taken in the idle state and decoded in the next cycle; results then
// leave the output register one per cycle unless the output is stalled.
// No new item is taken before the last result of the one before is emitted; a line
// read-out reads the registered RAM port once per cycle unless the output stalls.
// Reset (asynchronous): buffer reads as spaces via per-entry written flags.
module char_lcd_frame_refresher #(
    parameter int MAX_WIDTH = 40,
    parameter int MAX_LINES = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [clfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [clfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             item_valid,
    output logic                             item_stall,
    input  clfr_pkg::item_t                  item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output clfr_pkg::result_t                result
);

    clfr_pkg::cmd_t    cmd;
    clfr_pkg::status_t st;

    // Sequencer
    clfr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .st         (st),
        .cmd        (cmd)
    );

    // Buffer, state and result register
    clfr_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_LINES (MAX_LINES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cmd          (cmd),
        .st           (st)
    );

endmodule

[tb/clfr_frame_check.sv]
`timescale 1ns / 1ps
// Frame check for the character LCD frame refresher: snoops the register port and both
// channels, predicts every result from its own copy of the frame and compares in order.
// Depends on clfr_pkg for the item and result types, modes, kinds, register indexes and codes.
module clfr_frame_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [clfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [clfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             item_valid,
    input  logic                             item_stall,
    input  clfr_pkg::item_t                  item,
    input  logic                             result_valid,
    input  logic                             result_stall,
    input  clfr_pkg::result_t                result,
    output int                               outstanding,
    output int                               fail_count
);

    localparam int COLS_MAX    = 40;
    localparam int ROWS_MAX    = 4;
    localparam int STORE_CELLS = COLS_MAX * ROWS_MAX;

    // Register copies
    logic [5:0] line_width;
    logic [2:0] line_count;
    logic [5:0] win_left;
    logic [1:0] win_top;
    logic [5:0] win_right;
    logic [1:0] win_bottom;
    logic       notify_en;

    // Display and write-position state
    logic [7:0]        frame_chars [STORE_CELLS];
    clfr_pkg::phase_t  show_phase;
    logic [1:0]        show_row;
    logic              redraw_due;
    logic [1:0]        write_row;
    logic [5:0]        write_col;
    logic [7:0]        write_total;

    // Results still to come, oldest first
    clfr_pkg::result_t lcd_out_due [$];
    clfr_pkg::result_t held;
    logic              have_held;
    int                mismatches = 0;

    assign fail_count = mismatches;

    function automatic int shown_width();
        if (line_width < 1) return 1;
        if (line_width > COLS_MAX) return COLS_MAX;
        return int'(line_width);
    endfunction

    function automatic int shown_lines();
        if (line_count < 1) return 1;
        if (line_count > ROWS_MAX) return ROWS_MAX;
        return int'(line_count);
    endfunction

    task automatic clear_frame();
        for (int i = 0; i < STORE_CELLS; i++) frame_chars[i] = clfr_pkg::CHAR_SPACE;
        line_width  = clfr_pkg::RST_LINE_WIDTH;
        line_count  = clfr_pkg::RST_LINE_COUNT;
        win_left    = clfr_pkg::RST_WINDOW_LEFT;
        win_top     = clfr_pkg::RST_WINDOW_TOP;
        win_right   = clfr_pkg::RST_WINDOW_RIGHT;
        win_bottom  = clfr_pkg::RST_WINDOW_BOTTOM;
        notify_en   = 1'b0;
        show_phase  = clfr_pkg::PH_RESET;
        show_row    = '0;
        redraw_due  = 1'b1;
        write_row   = clfr_pkg::RST_WINDOW_TOP;
        write_col   = '0;
        write_total = '0;
        lcd_out_due.delete();
    endtask

    task automatic take_reg(input logic [clfr_pkg::CFG_INDEX_W-1:0] idx,
                            input logic [5:0] val);
        unique case (idx)
            clfr_pkg::REG_LINE_WIDTH:    line_width = val;
            clfr_pkg::REG_LINE_COUNT:    line_count = val[2:0];
            clfr_pkg::REG_WINDOW_LEFT:   win_left   = val;
            clfr_pkg::REG_WINDOW_TOP:    win_top    = val[1:0];
            clfr_pkg::REG_WINDOW_RIGHT:  win_right  = val;
            clfr_pkg::REG_WINDOW_BOTTOM: win_bottom = val[1:0];
            clfr_pkg::REG_NOTIFY_ENABLE: notify_en  = val[0];
            default: ;
        endcase
    endtask

    // One result is held back so the last of a burst can be flagged
    task automatic emit(input logic [1:0] kind, input logic rs, input logic [7:0] code,
                        input logic [7:0] count);
        if (have_held) lcd_out_due.push_back(held);
        held.kind           = kind;
        held.rs_level       = rs;
        held.bus_byte       = code;
        held.burst_last     = 1'b0;
        held.accepted_count = count;
        have_held           = 1'b1;
    endtask

    task automatic position_cmd();
        emit(clfr_pkg::KIND_BUS, 1'b0,
             clfr_pkg::CMD_SET_ADDR | ((show_row != 0) ? clfr_pkg::ADDR_LINE_OFFSET : 8'h00),
             '0);
    endtask

    task automatic begin_redraw();
        show_row   = '0;
        show_phase = clfr_pkg::PH_ADDR;
        position_cmd();
    endtask

    // Window write: invalid windows drop everything, a full window parks the column
    task automatic store_char(input logic [7:0] code);
        int w;
        int span;
        int idx;
        w = shown_width();
        if (win_left > win_right || win_top > win_bottom ||
            int'(win_right) >= w || int'(win_bottom) >= shown_lines())
            return;
        span = int'(win_right) - int'(win_left) + 1;
        if (write_row > win_bottom || int'(write_col) >= span)
            return;
        idx = int'(write_row) * w + int'(win_left) + int'(write_col);
        if (idx < STORE_CELLS) frame_chars[idx] = code;
        if (write_total != clfr_pkg::TOTAL_MAX) write_total++;
        write_col++;
        if (int'(write_col) >= span && write_row < win_bottom)
        begin
            write_col = '0;
            write_row++;
        end
    endtask

    task automatic refresh_step(input clfr_pkg::item_t it);
        int w;
        int base;
        have_held = 1'b0;
        unique case (it.mode)
            clfr_pkg::MODE_START:
            begin
                show_phase = clfr_pkg::PH_RESET;
                show_row   = '0;
                redraw_due = 1'b1;
                emit(clfr_pkg::KIND_BUS, 1'b0, clfr_pkg::CMD_FUNCTION_SET, '0);
                emit(clfr_pkg::KIND_BUS, 1'b0, clfr_pkg::CMD_DISPLAY_ON, '0);
                emit(clfr_pkg::KIND_BUS, 1'b0, clfr_pkg::CMD_ENTRY_MODE, '0);
                emit(clfr_pkg::KIND_BUS, 1'b0, clfr_pkg::CMD_CURSOR_SHIFT, '0);
            end
            clfr_pkg::MODE_DATA:
            begin
                store_char(it.data_byte);
                if (it.end_of_write)
                begin
                    if (show_phase == clfr_pkg::PH_IDLE) begin_redraw();
                    else redraw_due = 1'b1;
                    emit(clfr_pkg::KIND_SUMMARY, 1'b0, '0, write_total);
                    write_row   = win_top;
                    write_col   = '0;
                    write_total = '0;
                end
            end
            clfr_pkg::MODE_BUS_DONE:
            begin
                w = shown_width();
                if (show_phase == clfr_pkg::PH_ADDR)
                begin
                    base       = int'(show_row) * w;
                    show_phase = clfr_pkg::PH_DATA;
                    for (int i = 0; i < w; i++)
                        emit(clfr_pkg::KIND_BUS, 1'b1,
                             (base + i < STORE_CELLS) ? frame_chars[base + i]
                                                      : clfr_pkg::CHAR_SPACE,
                             '0);
                end
                else if (show_phase == clfr_pkg::PH_DATA)
                begin
                    // a shrunk line count ends the refresh after the current line
                    if (int'(show_row) + 1 < shown_lines())
                    begin
                        show_row++;
                        show_phase = clfr_pkg::PH_ADDR;
                        position_cmd();
                    end
                    else
                    begin
                        show_phase = clfr_pkg::PH_IDLE;
                    end
                end
                else if (show_phase == clfr_pkg::PH_RESET)
                begin
                    show_phase = clfr_pkg::PH_IDLE;
                end
                if (show_phase == clfr_pkg::PH_IDLE)
                begin
                    if (redraw_due)
                    begin
                        redraw_due = 1'b0;
                        begin_redraw();
                    end
                    else if (notify_en)
                    begin
                        emit(clfr_pkg::KIND_NOTICE, 1'b0, '0, '0);
                    end
                end
            end
            default: ;
        endcase
        if (have_held)
        begin
            held.burst_last = 1'b1;
            lcd_out_due.push_back(held);
        end
    endtask

    task automatic check_result(input clfr_pkg::result_t got);
        clfr_pkg::result_t want;
        if (lcd_out_due.size() == 0)
        begin
            $error("result with nothing due: kind %0d bus_byte 0x%02h", got.kind, got.bus_byte);
            mismatches++;
        end
        else
        begin
            want = lcd_out_due.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.rs_level !== want.rs_level)
            begin
                $error("rs_level: expected %0d, got %0d", want.rs_level, got.rs_level);
                mismatches++;
            end
            if (got.bus_byte !== want.bus_byte)
            begin
                $error("bus_byte: expected 0x%02h, got 0x%02h", want.bus_byte, got.bus_byte);
                mismatches++;
            end
            if (got.burst_last !== want.burst_last)
            begin
                $error("burst_last: expected %0d, got %0d", want.burst_last, got.burst_last);
                mismatches++;
            end
            if (got.accepted_count !== want.accepted_count)
            begin
                $error("accepted_count: expected %0d, got %0d",
                       want.accepted_count, got.accepted_count);
                mismatches++;
            end
        end
    endtask

    // Results are checked before the item of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && !result_stall) check_result(result);
            if (cfg_write_en) take_reg(cfg_index, cfg_data);
            if (item_valid && !item_stall) refresh_step(item);
            outstanding <= lcd_out_due.size();
        end
    end

endmodule

[tb/char_lcd_frame_refresher_tb.sv]
`timescale 1ns / 1ps
// Top of the character LCD frame refresher testbench: clock, reset, register set-up,
// directed and random items, output stalls and verdict. Uses clfr_pkg and clfr_frame_check.
module char_lcd_frame_refresher_tb;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 21;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write_en;
    logic [clfr_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [clfr_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             item_valid;
    logic                             item_stall;
    clfr_pkg::item_t                  item;
    logic                             result_valid;
    logic                             result_stall;
    clfr_pkg::result_t                result;

    int outstanding;
    int fail_count;
    int send_idle_pct;
    int stall_pct;
    int quiet_cycles;

    char_lcd_frame_refresher u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    clfr_frame_check u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .outstanding  (outstanding),
        .fail_count   (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver stalls
    always @(posedge clk)
    begin
        result_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Watchdog: cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[char_lcd_frame_refresher] ERROR");
        $finish;
    end

    task automatic set_idling(input int sel);
        unique case (sel)
            1:
            begin
                send_idle_pct = 55;
                stall_pct     = 0;
            end
            2:
            begin
                send_idle_pct = 0;
                stall_pct     = 55;
            end
            3:
            begin
                send_idle_pct = 37;
                stall_pct     = 37;
            end
            default:
            begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
        endcase
    endtask

    // Offer one item, with random gaps before it, and hold it until taken
    task automatic send_item(input logic [1:0] mode, input logic [7:0] code, input logic eow);
        clfr_pkg::item_t it;
        it.mode         = mode;
        it.data_byte    = code;
        it.end_of_write = eow;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall) @(posedge clk);
    endtask

    // Wait for every due result, then let the pipeline empty
    task automatic settle();
        item_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [clfr_pkg::CFG_INDEX_W-1:0] idx, input int val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= clfr_pkg::CFG_DATA_W'(val);
        @(posedge clk);
    endtask

    task automatic load_setting(input int lw, lc, wl, wt, wr, wb, ne);
        put_reg(clfr_pkg::REG_LINE_WIDTH, lw);
        put_reg(clfr_pkg::REG_LINE_COUNT, lc);
        put_reg(clfr_pkg::REG_WINDOW_LEFT, wl);
        put_reg(clfr_pkg::REG_WINDOW_TOP, wt);
        put_reg(clfr_pkg::REG_WINDOW_RIGHT, wr);
        put_reg(clfr_pkg::REG_WINDOW_BOTTOM, wb);
        put_reg(clfr_pkg::REG_NOTIFY_ENABLE, ne);
        cfg_write_en <= 1'b0;
    endtask

    // Mostly whole write calls and bus-done runs; some starts, noise and broken writes
    task automatic random_traffic(input int budget);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < budget)
        begin
            pick = $urandom_range(99);
            if (pick < 45)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(45, 12) : $urandom_range(8, 1);
                for (int k = 0; k < len; k++)
                    send_item(clfr_pkg::MODE_DATA, 8'($urandom), k == len - 1);
                sent += len;
            end
            else if (pick < 83)
            begin
                len = $urandom_range(4, 1);
                repeat (len) send_item(clfr_pkg::MODE_BUS_DONE, 8'($urandom), 1'($urandom));
                sent += len;
            end
            else if (pick < 88)
            begin
                send_item(clfr_pkg::MODE_START, 8'($urandom), 1'($urandom));
                sent++;
            end
            else if (pick < 93)
            begin
                send_item(MODE_UNUSED, 8'($urandom), 1'($urandom));
            end
            else if (pick < 96)
            begin
                settle();
            end
            else
            begin
                // write call with no end marker
                send_item(clfr_pkg::MODE_DATA, 8'($urandom), 1'b0);
                sent++;
            end
        end
    endtask

    // Leave a refresh part-way through so the next setting lands mid-refresh
    task automatic leave_refresh_open();
        send_item(clfr_pkg::MODE_START, 8'($urandom), 1'($urandom));
        repeat (3) send_item(clfr_pkg::MODE_BUS_DONE, 8'($urandom), 1'($urandom));
    endtask

    task automatic run_phase(input int idling, lw, lc, wl, wt, wr, wb, ne);
        settle();
        load_setting(lw, lc, wl, wt, wr, wb, ne);
        set_idling(idling);
        random_traffic(PHASE_ITEMS);
        leave_refresh_open();
    endtask

    initial
    begin
        int gw;
        int gc;
        int gl;
        int gr;
        int gt;
        int gb;
        rst_n         = 1'b0;
        cfg_write_en  = 1'b0;
        cfg_index     = clfr_pkg::REG_LINE_WIDTH;
        cfg_data      = '0;
        item_valid    = 1'b0;
        item          = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first refresh after reset, writes, noise, start mid-refresh
        send_item(clfr_pkg::MODE_BUS_DONE, 8'h00, 1'b0);
        send_item(clfr_pkg::MODE_BUS_DONE, 8'hFF, 1'b1);
        send_item(clfr_pkg::MODE_BUS_DONE, 8'h00, 1'b0);
        send_item(clfr_pkg::MODE_BUS_DONE, 8'h00, 1'b0);
        send_item(clfr_pkg::MODE_BUS_DONE, 8'h00, 1'b0);
        send_item(clfr_pkg::MODE_DATA, 8'h00, 1'b0);
        send_item(clfr_pkg::MODE_DATA, 8'hFF, 1'b0);
        send_item(clfr_pkg::MODE_DATA, 8'hA5, 1'b1);
        send_item(MODE_UNUSED, 8'hFF, 1'b1);
        send_item(clfr_pkg::MODE_DATA, 8'h5A, 1'b1);
        send_item(clfr_pkg::MODE_BUS_DONE, 8'h00, 1'b0);
        send_item(clfr_pkg::MODE_START, 8'hFF, 1'b1);
        repeat (6) send_item(clfr_pkg::MODE_BUS_DONE, 8'h00, 1'b0);

        // Extremes of geometry, clamped values, invalid windows, a tiny window
        run_phase(1, 40, 4, 0, 0, 39, 3, 1);
        run_phase(2, 1, 1, 0, 0, 0, 0, 1);
        run_phase(3, 0, 0, 0, 0, 0, 0, 0);
        run_phase(0, 63, 7, 5, 1, 12, 2, 1);
        run_phase(1, 20, 2, 10, 0, 3, 1, 1);
        run_phase(2, 8, 4, 0, 0, 39, 3, 0);
        run_phase(3, 16, 2, 0, 2, 15, 3, 1);
        run_phase(0, 16, 4, 0, 3, 15, 1, 0);
        run_phase(1, 8, 3, 2, 1, 5, 2, 1);
        run_phase(2, 40, 4, 39, 3, 39, 3, 1);

        // Random valid geometry
        gw = $urandom_range(40, 1);
        gc = $urandom_range(4, 1);
        gl = $urandom_range(gw - 1);
        gr = $urandom_range(gw - 1, gl);
        gt = $urandom_range(gc - 1);
        gb = $urandom_range(gc - 1, gt);
        run_phase(3, gw, gc, gl, gt, gr, gb, $urandom_range(1));

        settle();
        if (fail_count == 0 && outstanding == 0)
            $display("[char_lcd_frame_refresher] OK");
        else
            $display("[char_lcd_frame_refresher] ERROR");
        $finish;
    end

endmodule
